>>> hdl/assert_macros.svh
// assertion macros shared by the timed wait slot table rtl
// depends on a clock named clock and a reset named reset in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TWS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define TWS_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define TWS_ASSERT_ALWAYS(label, cond, msg)
`define TWS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> hdl/tws_pkg.sv
// shared constants for the timed wait slot table
// no dependencies
package tws_pkg;
   localparam int SLOTS_DEF     = 8;
   localparam int COND_BITS_DEF = 8;
   localparam int CNT_W         = 16;
   localparam int SLOT_W        = 3;
   localparam int REL_W         = 16;
   localparam int COND_OUT_W    = 8;

   localparam logic [CNT_W-1:0] COUNT_LAST = 16'hFFFE;
   localparam logic [CNT_W-1:0] FREE_MARK  = 16'hFFFF;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_ARM  = 1'b1;
endpackage

>>> hdl/tws_if.sv
// request and response channel interfaces of the timed wait slot table
// depends on tws_pkg
interface tws_req_if;
   import tws_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic [SLOT_W-1:0]       slot;
   logic [REL_W-1:0]        reltime;
   logic [COND_OUT_W-1:0]   cond_id;
   modport source (output valid, kind, slot, reltime, cond_id, input ready);
   modport sink (input valid, kind, slot, reltime, cond_id, output ready);
endinterface

interface tws_rsp_if;
   import tws_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [SLOT_W-1:0]       released_slot;
   logic [COND_OUT_W-1:0]   released_cond;
   logic                    last;
   modport source (output valid, released_slot, released_cond, last, input ready);
   modport sink (input valid, released_slot, released_cond, last, output ready);
endinterface

>>> hdl/timed_wait_slot_table_unit.sv
// timed wait slot table: tick counter, slot memory and release scan
// an arm transfer does not hold off the input; after a tick transfer the input is held off
// while the scan walks the slots and a release is still parked, longer under response stalls
// the last release of a tick is presented once the scan has compared the lowest slot,
// earlier releases once the next lower match is read
// reset: counter zero, all slots free, condition ids not cleared; uses tws_slot_mem, tws_scan
module timed_wait_slot_table_unit #(
   parameter int SLOTS     = tws_pkg::SLOTS_DEF,
   parameter int COND_BITS = tws_pkg::COND_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   tws_req_if.sink   req_if,
   tws_rsp_if.source rsp_if
);
   import tws_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 busy;
   logic                 accept;
   logic                 tick_go;
   logic                 arm_go;
   logic [IDX_W-1:0]     arm_idx;
   logic [CNT_W-1:0]     next_count;
   logic [CNT_W-1:0]     dl_sum;
   logic [CNT_W-1:0]     arm_dl;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_idx;
   logic [CNT_W-1:0]     rd_dl;
   logic [COND_BITS-1:0] rd_cond;

   assign req_if.ready = !busy && !reset;

   always_comb begin
      accept     = req_if.valid && req_if.ready;
      tick_go    = accept && (req_if.kind == KIND_TICK);
      arm_go     = accept && (req_if.kind == KIND_ARM) && (32'(req_if.slot) < SLOTS);
      arm_idx    = IDX_W'(req_if.slot);
      next_count = count_ff + CNT_W'(1);
      dl_sum     = next_count + req_if.reltime;
      arm_dl     = (dl_sum == FREE_MARK) ? '0 : dl_sum;
      count_in   = count_ff;
      if (tick_go) begin
         count_in = (count_ff == COUNT_LAST) ? '0 : next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   tws_slot_mem #(
      .SLOTS     (SLOTS),
      .COND_BITS (COND_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (arm_go),
      .wr_idx  (arm_idx),
      .wr_dl   (arm_dl),
      .wr_cond (COND_BITS'(req_if.cond_id)),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_dl   (rd_dl),
      .rd_cond (rd_cond)
   );

   tws_scan #(
      .SLOTS     (SLOTS),
      .COND_BITS (COND_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (tick_go),
      .count   (count_ff),
      .arm_en  (arm_go),
      .arm_idx (arm_idx),
      .rd_en   (rd_en),
      .rd_idx  (rd_idx),
      .rd_dl   (rd_dl),
      .rd_cond (rd_cond),
      .busy    (busy),
      .rsp_if  (rsp_if)
   );
endmodule

>>> hdl/tws_slot_mem.sv
// slot memory: deadline and condition id per slot, one write and one read port
// depends on tws_pkg
module tws_slot_mem #(
   parameter int SLOTS     = tws_pkg::SLOTS_DEF,
   parameter int COND_BITS = tws_pkg::COND_BITS_DEF,
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_idx,
   input  logic [tws_pkg::CNT_W-1:0] wr_dl,
   input  logic [COND_BITS-1:0]      wr_cond,
   input  logic                      rd_en,
   input  logic [IDX_W-1:0]          rd_idx,
   output logic [tws_pkg::CNT_W-1:0] rd_dl,
   output logic [COND_BITS-1:0]      rd_cond
);
   import tws_pkg::*;

   logic [CNT_W-1:0]     dl_mem   [SLOTS];
   logic [COND_BITS-1:0] cond_mem [SLOTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_idx]   <= wr_dl;
         cond_mem[wr_idx] <= wr_cond;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_dl   <= dl_mem[rd_idx];
         rd_cond <= cond_mem[rd_idx];
      end
   end
endmodule

>>> hdl/tws_scan.sv
// release scan: walks the slot memory from the top slot down after a tick,
// holds one pending release to mark the last one, drives the response channel
// depends on tws_pkg, tws_rsp_if and assert_macros.svh
`include "assert_macros.svh"

module tws_scan #(
   parameter int SLOTS     = tws_pkg::SLOTS_DEF,
   parameter int COND_BITS = tws_pkg::COND_BITS_DEF,
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tws_pkg::CNT_W-1:0] count,
   input  logic                      arm_en,
   input  logic [IDX_W-1:0]          arm_idx,
   output logic                      rd_en,
   output logic [IDX_W-1:0]          rd_idx,
   input  logic [tws_pkg::CNT_W-1:0] rd_dl,
   input  logic [COND_BITS-1:0]      rd_cond,
   output logic                      busy,
   tws_rsp_if.source                 rsp_if
);
   import tws_pkg::*;

   logic                  scan_act_ff, scan_act_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  b_valid_ff, b_valid_in;
   logic [IDX_W-1:0]      b_idx_ff, b_idx_in;
   logic [SLOTS-1:0]      valid_ff, valid_in;
   logic                  hold_v_ff, hold_v_in;
   logic [IDX_W-1:0]      hold_slot_ff, hold_slot_in;
   logic [COND_BITS-1:0]  hold_cond_ff, hold_cond_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [COND_OUT_W-1:0] rsp_cond_ff, rsp_cond_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic b_match;
   logic out_busy;
   logic stall;
   logic finish;
   logic push;

   always_comb begin
      b_match  = b_valid_ff && valid_ff[b_idx_ff] && (rd_dl == count);
      out_busy = rsp_valid_ff && !rsp_if.ready;
      stall    = b_match && hold_v_ff && out_busy;
      rd_en    = scan_act_ff && !stall;
      rd_idx   = scan_idx_ff;
      finish   = hold_v_ff && !scan_act_ff && !b_valid_ff && !out_busy;
      push     = (b_match && hold_v_ff && !stall) || finish;
      busy     = scan_act_ff || b_valid_ff || hold_v_ff;
   end

   always_comb begin
      scan_act_in  = scan_act_ff;
      scan_idx_in  = scan_idx_ff;
      b_valid_in   = b_valid_ff;
      b_idx_in     = b_idx_ff;
      valid_in     = valid_ff;
      hold_v_in    = hold_v_ff;
      hold_slot_in = hold_slot_ff;
      hold_cond_in = hold_cond_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_cond_in  = rsp_cond_ff;
      rsp_last_in  = rsp_last_ff;

      if (start) begin
         scan_act_in = 1'b1;
         scan_idx_in = IDX_W'(SLOTS - 1);
      end else if (rd_en) begin
         if (scan_idx_ff == '0) begin
            scan_act_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff - IDX_W'(1);
         end
      end

      if (!stall) begin
         b_valid_in = rd_en;
         if (rd_en) begin
            b_idx_in = scan_idx_ff;
         end
      end

      if (arm_en) begin
         valid_in[arm_idx] = 1'b1;
      end

      // new match: free the slot and park it until the next match or scan end
      if (b_match && !stall) begin
         valid_in[b_idx_ff] = 1'b0;
         hold_v_in          = 1'b1;
         hold_slot_in       = b_idx_ff;
         hold_cond_in       = rd_cond;
      end else if (finish) begin
         hold_v_in = 1'b0;
      end

      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = SLOT_W'(hold_slot_ff);
         rsp_cond_in  = COND_OUT_W'(hold_cond_ff);
         rsp_last_in  = finish;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_act_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         valid_ff     <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_act_ff  <= scan_act_in;
         b_valid_ff   <= b_valid_in;
         valid_ff     <= valid_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff  <= scan_idx_in;
      b_idx_ff     <= b_idx_in;
      hold_slot_ff <= hold_slot_in;
      hold_cond_ff <= hold_cond_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_cond_ff  <= rsp_cond_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.released_slot = rsp_slot_ff;
   assign rsp_if.released_cond = rsp_cond_ff;
   assign rsp_if.last          = rsp_last_ff;

   `TWS_ASSERT_ALWAYS(a_no_overwrite, !(push && out_busy), "result overwritten before transfer")
   `TWS_ASSERT_ALWAYS(a_start_idle, !(start && busy), "tick started while scan busy")
   `TWS_ASSERT_NEXT(a_slot_freed, b_match && !stall, !valid_ff[$past(b_idx_ff)], "released slot not freed")
   `TWS_ASSERT_NEXT(a_last_drains, push && finish, !hold_v_ff && rsp_last_ff, "last release not drained")
endmodule

>>> test/timed_wait_slot_table_unit_tb.sv
// testbench for timed_wait_slot_table_unit: directed arms and ticks, then random traffic
// with stalls on both sides, checked against an in-bench slot table
// depends on tws_pkg, tws_if and the rtl of timed_wait_slot_table_unit
`timescale 1ns / 1ps

module timed_wait_slot_table_unit_tb;
   import tws_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 200;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [SLOT_W-1:0]     slot;
      logic [COND_OUT_W-1:0] cond;
      logic                  last;
   } slot_release_type;

   class release_scoreboard_type;
      logic [CNT_W-1:0]      count_now;
      logic [CNT_W-1:0]      deadline[SLOTS_DEF];
      logic [COND_OUT_W-1:0] cond_store[SLOTS_DEF];
      slot_release_type      due[$];
      int                    errors;
      int                    arms;
      int                    ticks;
      int                    releases;

      function new();
         count_now = '0;
         foreach (deadline[i]) deadline[i] = FREE_MARK;
         foreach (cond_store[i]) cond_store[i] = '0;
         errors = 0;
         arms = 0;
         ticks = 0;
         releases = 0;
      endfunction

      function void note_request(logic kind, logic [SLOT_W-1:0] slot,
                                 logic [REL_W-1:0] rel, logic [COND_OUT_W-1:0] cid);
         logic [CNT_W-1:0] sum;
         int               first;
         slot_release_type item;
         if (kind == KIND_ARM) begin
            arms++;
            sum = count_now + 16'd1 + rel;
            deadline[slot] = (sum == FREE_MARK) ? '0 : sum;
            cond_store[slot] = cid;
         end else begin
            ticks++;
            count_now = (count_now == COUNT_LAST) ? '0 : count_now + 16'd1;
            first = due.size();
            for (int i = SLOTS_DEF - 1; i >= 0; i--) begin
               if (deadline[i] == count_now) begin
                  deadline[i] = FREE_MARK;
                  item.slot = i[SLOT_W-1:0];
                  item.cond = cond_store[i];
                  item.last = 1'b0;
                  due.push_back(item);
               end
            end
            if (due.size() > first) due[due.size() - 1].last = 1'b1;
         end
      endfunction

      function void check_release(logic [SLOT_W-1:0] slot, logic [COND_OUT_W-1:0] cond,
                                  logic last);
         slot_release_type want;
         if (due.size() == 0) begin
            errors++;
            $display("%0t: unexpected release, expected none, got slot %0d cond %h last %b",
                     $time, slot, cond, last);
            return;
         end
         want = due.pop_front();
         releases++;
         if (slot !== want.slot) begin
            errors++;
            $display("%0t: released_slot expected %0d actual %0d", $time, want.slot, slot);
         end
         if (cond !== want.cond) begin
            errors++;
            $display("%0t: released_cond expected %h actual %h", $time, want.cond, cond);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, last);
         end
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void final_check();
         if (due.size() != 0) begin
            errors++;
            $display("%0t: %0d releases expected but never seen, next slot %0d cond %h",
                     $time, due.size(), due[0].slot, due[0].cond);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   bit   hold_armed;
   int   cycle_count;

   release_scoreboard_type sb = new();

   tws_req_if req_if();
   tws_rsp_if rsp_if();

   timed_wait_slot_table_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // result transfers
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_release(rsp_if.released_slot, rsp_if.released_cond, rsp_if.last);
   end

   // result side ready, with one long hold-off
   initial begin : response_sink
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_if.ready = 1'b0;
            hold_left--;
         end else if (steady || reset) begin
            rsp_if.ready = !reset;
         end else begin
            rsp_if.ready = ($urandom_range(0, 99) >= 15);
         end
      end
   end

   task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                            input logic [REL_W-1:0] rel, input logic [COND_OUT_W-1:0] cid);
      if (!steady) begin
         while ($urandom_range(0, 99) < 15) begin
            req_if.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_if.valid = 1'b1;
      req_if.kind = kind;
      req_if.slot = slot;
      req_if.reltime = rel;
      req_if.cond_id = cid;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(kind, slot, rel, cid);
      @(negedge clock);
   endtask

   task automatic send_tick();
      send_item(KIND_TICK, SLOT_W'($urandom_range(0, 7)), REL_W'($urandom_range(0, 65535)),
                COND_OUT_W'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      logic [REL_W-1:0] rel;
      int               pick;
      reset = 1'b1;
      steady = 1'b0;
      hold_armed = 1'b0;
      cycle_count = 0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_TICK;
      req_if.slot = '0;
      req_if.reltime = '0;
      req_if.cond_id = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tick, zero reltime, full table, re-arm, shared deadline
      send_tick();
      send_item(KIND_ARM, 3'd0, 16'd0, 8'hFF);
      send_tick();
      for (int s = SLOTS_DEF - 1; s >= 0; s--)
         send_item(KIND_ARM, s[SLOT_W-1:0], 16'd0, 8'h00 + 8'(s * 37));
      send_tick();
      send_item(KIND_ARM, 3'd3, 16'd5, 8'h11);
      send_item(KIND_ARM, 3'd3, 16'd1, 8'h22);
      send_tick();
      send_tick();
      send_item(KIND_ARM, 3'd5, 16'hFFFF, 8'hA5);
      send_item(KIND_ARM, 3'd6, 16'h8000, 8'h5A);
      send_item(KIND_ARM, 3'd2, 16'd2, 8'h3C);
      send_item(KIND_ARM, 3'd4, 16'd2, 8'hC3);
      repeat (3) send_tick();
      wait_drained();

      // random traffic
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 60) hold_armed = 1'b1;
         if (i == 120) wait_drained();
         steady = (i >= 150 && i < 190);
         if ($urandom_range(0, 99) < 45) begin
            send_tick();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
               rel = REL_W'($urandom_range(0, 12));
            else if (pick < 90)
               rel = REL_W'($urandom_range(0, 65535));
            else if (pick < 95)
               rel = FREE_MARK - (sb.count_now + 16'd1 + 16'($urandom_range(0, 6)));
            else
               rel = REL_W'($urandom_range(65530, 65535));
            send_item(KIND_ARM, SLOT_W'($urandom_range(0, 7)), rel,
                      COND_OUT_W'($urandom_range(0, 255)));
         end
      end
      wait_drained();
      steady = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      sb.final_check();

      $display("covered %0d arms and %0d ticks with %0d releases checked,", sb.arms, sb.ticks,
               sb.releases);
      $display("including deadlines near the count limit and a long result-side hold-off");
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule
